FILE: src/dbs_pkg.sv
// ----------------------------------------------------------------------------
// dbs_pkg: shared types and constants of the depth bucket sorter
// Widths of the channel fields, default sizes, operation codes and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int DBS_BUCKETS     = 1024;
  localparam int DBS_POOL_SIZE   = 64;
  localparam int DBS_HANDLE_BITS = 16;

  localparam int DBS_KEY_W    = 16;
  localparam int DBS_HANDLE_W = 16;
  localparam int DBS_BKT_W    = 10;

  localparam logic DBS_OP_INSERT = 1'b0;
  localparam logic DBS_OP_FLUSH  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;      // write one zero entry of the reset clearing pass
    logic ins_rd;      // latch insert request, read its bucket entry
    logic ins_wr;      // link node into bucket (or drop when pool full)
    logic scan_load;   // start bucket scan at the highest used bucket
    logic scan_step;   // move scan to next lower bucket and read it
    logic bkt_take;    // clear scanned bucket, read its head node
    logic node_adv;    // follow the next pointer, read that node
    logic emit;        // load output register with current node
    logic emit_empty;  // load output register with the empty marker
    logic finish;      // flush done: reset pool, overflow and counters
  } dbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic pool_empty;
    logic occ;
    logic at_tail;
    logic last_node;
    logic out_free;
  } dbs_sts_t;

endpackage

FILE: src/dbs_if.sv
// ----------------------------------------------------------------------------
// dbs_in_if / dbs_out_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface dbs_in_if;
  import dbs_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic signed [DBS_KEY_W-1:0] depth_key;
  logic [DBS_HANDLE_W-1:0]     prim_handle;

  modport source (output valid, operation, depth_key, prim_handle, input ready);
  modport sink   (input valid, operation, depth_key, prim_handle, output ready);
endinterface

interface dbs_out_if;
  import dbs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DBS_HANDLE_W-1:0] out_handle;
  logic [DBS_BKT_W-1:0]    out_bucket;
  logic                    empty_res;
  logic                    overflow;
  logic                    last;

  modport source (output valid, out_handle, out_bucket, empty_res, overflow, last,
                  input ready);
  modport sink   (input valid, out_handle, out_bucket, empty_res, overflow, last,
                  output ready);
endinterface

FILE: src/dbs_ctrl.sv
// ----------------------------------------------------------------------------
// dbs_ctrl: sequencer of the depth bucket sorter
// Runs the reset clearing pass, insert (read, then write) and the flush walk
// (bucket scan, list walk, result emission) by commands to the datapath.
// ----------------------------------------------------------------------------
module dbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  input  dbs_pkg::dbs_sts_t sts,
  output dbs_pkg::dbs_cmd_t cmd
);
  import dbs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_INS_WR,
    ST_FL_START,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == DBS_OP_INSERT) begin
            cmd.ins_rd = 1'b1;
            state_nxt  = ST_INS_WR;
          end else begin
            state_nxt = ST_FL_START;
          end
        end
      end
      ST_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FL_START: begin
        if (sts.pool_empty) begin
          if (sts.out_free) begin
            cmd.emit_empty = 1'b1;
            cmd.finish     = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          cmd.scan_load = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.occ) begin
          cmd.bkt_take = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.at_tail) begin
            if (sts.last_node) begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              // bucket exhausted, more primitives below
              cmd.scan_step = 1'b1;
              state_nxt     = ST_SCAN;
            end
          end else begin
            cmd.node_adv = 1'b1;
          end
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == ST_IDLE)
    else $error("ready raised outside idle");

  a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_operation == DBS_OP_FLUSH |=> state_r == ST_FL_START)
    else $error("accepted flush did not start walk");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit, cmd.emit_empty, cmd.ins_wr, cmd.clr_wr}))
    else $error("conflicting datapath commands");
`endif

endmodule

FILE: src/dbs_dp.sv
// ----------------------------------------------------------------------------
// dbs_dp: datapath of the depth bucket sorter
// Bucket table (occupied, head, tail), node pool (next, handle), pool
// counters, scan/walk pointers and the result output register.
// ----------------------------------------------------------------------------
module dbs_dp #(
  parameter int BUCKETS     = dbs_pkg::DBS_BUCKETS,
  parameter int POOL_SIZE   = dbs_pkg::DBS_POOL_SIZE,
  parameter int HANDLE_BITS = dbs_pkg::DBS_HANDLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dbs_pkg::dbs_cmd_t                   cmd,
  output dbs_pkg::dbs_sts_t                   sts,
  input  logic signed [dbs_pkg::DBS_KEY_W-1:0] in_depth_key,
  input  logic [dbs_pkg::DBS_HANDLE_W-1:0]    in_prim_handle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dbs_pkg::DBS_HANDLE_W-1:0]    out_handle,
  output logic [dbs_pkg::DBS_BKT_W-1:0]       out_bucket,
  output logic                                out_empty_res,
  output logic                                out_overflow,
  output logic                                out_last
);
  import dbs_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int PW = $clog2(POOL_SIZE);
  localparam int CW = PW + 1;
  localparam int EW = 1 + 2 * PW;  // {occupied, head, tail}
  localparam int XW = 48;          // scratch width for handle resizing

  // bucket table
  logic [EW-1:0] bkt_mem [BUCKETS];
  logic [EW-1:0] bkt_rd_r;
  logic [BW-1:0] bkt_raddr;
  logic          bkt_ren;
  logic [BW-1:0] bkt_waddr;
  logic [EW-1:0] bkt_wdata;
  logic          bkt_wen;
  logic          rd_occ;
  logic [PW-1:0] rd_head;
  logic [PW-1:0] rd_tail;

  // node pool
  logic [PW-1:0]          nnext_mem [POOL_SIZE];
  logic [HANDLE_BITS-1:0] nhdl_mem  [POOL_SIZE];
  logic [PW-1:0]          nnext_rd_r;
  logic [HANDLE_BITS-1:0] nhdl_rd_r;
  logic [PW-1:0]          node_raddr;
  logic                   node_ren;

  // control registers
  logic [BW-1:0]          clr_addr_r;
  logic [BW-1:0]          ins_b_r;
  logic [HANDLE_BITS-1:0] ins_h_r;
  logic [CW-1:0]          nodes_used_r;
  logic                   ovf_r;
  logic [BW-1:0]          max_b_r;
  logic [BW-1:0]          scan_b_r;
  logic [PW-1:0]          cur_r;
  logic [PW-1:0]          tail_r;
  logic [CW-1:0]          emitted_r;
  logic                   out_valid_r;

  logic [BW-1:0]  key_b;
  logic [15:0]    key_raw;
  logic           full;
  logic           ins_do;
  logic [PW-1:0]  new_node;
  logic [XW-1:0]  h_in_ext;
  logic [XW-1:0]  h_out_ext;
  logic [15:0]    sb_ext;

  // clamp key to 0..BUCKETS-1
  assign key_raw = in_depth_key;
  always_comb begin
    if (key_raw[15])                      key_b = '0;
    else if (key_raw >= 16'(BUCKETS))     key_b = BW'(BUCKETS - 1);
    else                                  key_b = key_raw[BW-1:0];
  end

  assign rd_occ   = bkt_rd_r[EW-1];
  assign rd_head  = bkt_rd_r[2*PW-1:PW];
  assign rd_tail  = bkt_rd_r[PW-1:0];
  assign full     = (nodes_used_r == CW'(POOL_SIZE));
  assign ins_do   = cmd.ins_wr && !full;
  assign new_node = nodes_used_r[PW-1:0];
  assign h_in_ext = XW'(in_prim_handle);
  assign h_out_ext = XW'(nhdl_rd_r);
  assign sb_ext   = 16'(scan_b_r);

  // bucket table ports
  always_comb begin
    bkt_ren   = cmd.ins_rd || cmd.scan_load || cmd.scan_step;
    bkt_raddr = key_b;
    if (cmd.scan_load)      bkt_raddr = max_b_r;
    else if (cmd.scan_step) bkt_raddr = scan_b_r - BW'(1);
    bkt_wen   = cmd.clr_wr || ins_do || cmd.bkt_take;
    bkt_waddr = clr_addr_r;
    bkt_wdata = '0;
    if (ins_do) begin
      bkt_waddr = ins_b_r;
      bkt_wdata = {1'b1, (rd_occ ? rd_head : new_node), new_node};
    end else if (cmd.bkt_take) begin
      bkt_waddr = scan_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_wen) bkt_mem[bkt_waddr] <= bkt_wdata;
    if (bkt_ren) bkt_rd_r <= bkt_mem[bkt_raddr];
  end

  // node pool ports
  assign node_ren   = cmd.bkt_take || cmd.node_adv;
  assign node_raddr = cmd.bkt_take ? rd_head : nnext_rd_r;

  always_ff @(posedge clk) begin
    if (ins_do) begin
      nhdl_mem[new_node] <= ins_h_r;
      // tail's next pointer is only followed once another node hangs off it
      if (rd_occ) nnext_mem[rd_tail] <= new_node;
    end
    if (node_ren) begin
      nhdl_rd_r  <= nhdl_mem[node_raddr];
      nnext_rd_r <= nnext_mem[node_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ins_rd) begin
      ins_b_r <= key_b;
      ins_h_r <= h_in_ext[HANDLE_BITS-1:0];
    end
    if (cmd.scan_load)      scan_b_r <= max_b_r;
    else if (cmd.scan_step) scan_b_r <= scan_b_r - BW'(1);
    if (cmd.bkt_take) begin
      cur_r  <= rd_head;
      tail_r <= rd_tail;
    end else if (cmd.node_adv) begin
      cur_r <= nnext_rd_r;
    end
    if (cmd.emit) begin
      out_handle    <= h_out_ext[DBS_HANDLE_W-1:0];
      out_bucket    <= sb_ext[DBS_BKT_W-1:0];
      out_empty_res <= 1'b0;
      out_overflow  <= ovf_r;
      out_last      <= sts.last_node && sts.at_tail;
    end else if (cmd.emit_empty) begin
      out_handle    <= '0;
      out_bucket    <= '0;
      out_empty_res <= 1'b1;
      out_overflow  <= ovf_r;
      out_last      <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      nodes_used_r <= '0;
      ovf_r        <= 1'b0;
      max_b_r      <= '0;
      emitted_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + BW'(1);
      if (cmd.finish) begin
        nodes_used_r <= '0;
        ovf_r        <= 1'b0;
        max_b_r      <= '0;
        emitted_r    <= '0;
      end else begin
        if (cmd.ins_wr && full) ovf_r <= 1'b1;
        if (ins_do) begin
          nodes_used_r <= nodes_used_r + CW'(1);
          if (nodes_used_r == '0 || ins_b_r > max_b_r) max_b_r <= ins_b_r;
        end
        if (cmd.emit) emitted_r <= emitted_r + CW'(1);
      end
      if (cmd.emit || cmd.emit_empty) out_valid_r <= 1'b1;
      else if (out_ready)             out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts            = '0;
    sts.clr_done   = (clr_addr_r == BW'(BUCKETS - 1));
    sts.pool_empty = (nodes_used_r == '0);
    sts.occ        = rd_occ;
    sts.at_tail    = (cur_r == tail_r);
    // only the primitive count decides the final result
    sts.last_node  = ((emitted_r + CW'(1)) == nodes_used_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

`ifndef SYNTHESIS
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= CW'(POOL_SIZE))
    else $error("node pool count past pool size");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emitted_r <= nodes_used_r)
    else $error("more results than stored primitives");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_empty) |-> sts.out_free)
    else $error("result loaded over a pending result");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> nodes_used_r == '0 && !ovf_r && out_valid_r && out_last)
    else $error("flush end did not leave a last result and empty pool");
`endif

endmodule

FILE: src/depth_bucket_sorter_unit.sv
// ----------------------------------------------------------------------------
// depth_bucket_sorter_unit: depth ordering of draw primitives by buckets
// Insert requests append a primitive handle to the list of its clamped depth
// bucket; a flush request emits all handles, highest bucket first, in insert
// order within a bucket, then empties the sorter.
//
// Channels: in_if (operation, depth_key, prim_handle) and out_if (out_handle,
// out_bucket, empty_res, overflow, last), both valid/ready; a request or a
// result moves when valid and ready are high at a rising edge.
// Insert: a bucket read, then a read-modify-write, no result; the next request
// waits for it. A full pool drops the insert and sets the sticky overflow.
// Flush: the bucket scan visits one bucket table entry per cycle, from the
// highest used bucket down to the lowest, and the list walk gives one result
// per cycle while out_if.ready stays high. An empty flush gives one result
// (empty_res and last set). The flag overflow rides on every result of a
// flush and is cleared with the pool.
// Reset: synchronous rst_n; afterwards a clearing pass writes every bucket
// table entry, during which in_if.ready stays low.
// Stalls: results sit in an output register; while out_if.ready is low the
// walk holds and no request is taken until the flush is complete.
// ----------------------------------------------------------------------------
module depth_bucket_sorter_unit #(
  parameter int BUCKETS     = dbs_pkg::DBS_BUCKETS,
  parameter int POOL_SIZE   = dbs_pkg::DBS_POOL_SIZE,
  parameter int HANDLE_BITS = dbs_pkg::DBS_HANDLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  dbs_in_if.sink    in_if,
  dbs_out_if.source out_if
);
  import dbs_pkg::*;

  dbs_cmd_t cmd;
  dbs_sts_t sts;

  dbs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_operation (in_if.operation),
    .in_ready     (in_if.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  dbs_dp #(
    .BUCKETS     (BUCKETS),
    .POOL_SIZE   (POOL_SIZE),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_depth_key   (in_if.depth_key),
    .in_prim_handle (in_if.prim_handle),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_handle     (out_if.out_handle),
    .out_bucket     (out_if.out_bucket),
    .out_empty_res  (out_if.empty_res),
    .out_overflow   (out_if.overflow),
    .out_last       (out_if.last)
  );

endmodule

FILE: test/draw_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// draw_order_checker: depth order predictor and result checker
// Watches the request and result channels of the depth bucket sorter, keeps
// its own copy of the stored primitives, works out the sorted draw order of
// each flush and compares every result with the oldest expected one.
// ----------------------------------------------------------------------------
module draw_order_checker (
  input  logic        clk,
  input  logic        rst_n,
  dbs_in_if           req_mon,
  dbs_out_if          res_mon,
  output int unsigned mismatch_cnt,
  output int unsigned pending_cnt
);
  import dbs_pkg::*;

  typedef struct packed {
    logic [DBS_HANDLE_W-1:0] handle;
    logic [DBS_BKT_W-1:0]    bucket;
    logic                    empty_res;
    logic                    overflow;
    logic                    last;
  } draw_res_t;

  // primitives held since the last flush, in arrival order
  logic [DBS_HANDLE_W-1:0] held_handle [DBS_POOL_SIZE];
  logic [DBS_BKT_W-1:0]    held_bucket [DBS_POOL_SIZE];
  int unsigned             held_cnt = 0;
  logic                    ovf_seen = 1'b0;

  draw_res_t   sorted_draws [$];
  draw_res_t   want;
  int unsigned err_total = 0;

  assign mismatch_cnt = err_total;

  task automatic report_mismatch(input string what);
    $display("%0t ns: draw order mismatch: %s", $time, what);
    err_total++;
  endtask

  function automatic logic [DBS_BKT_W-1:0] clamp_bucket(input int key);
    if (key < 0) return '0;
    if (key >= DBS_BUCKETS) return DBS_BKT_W'(DBS_BUCKETS - 1);
    return DBS_BKT_W'(key);
  endfunction

  function automatic draw_res_t make_draw(input logic [DBS_HANDLE_W-1:0] h,
                                          input logic [DBS_BKT_W-1:0] b,
                                          input logic e, input logic l);
    draw_res_t r;
    r.handle    = h;
    r.bucket    = b;
    r.empty_res = e;
    r.overflow  = ovf_seen;
    r.last      = l;
    return r;
  endfunction

  task automatic predict_request();
    logic [DBS_BKT_W-1:0] bkt;
    int unsigned          emitted;
    if (req_mon.operation == DBS_OP_INSERT) begin
      bkt = clamp_bucket($signed(req_mon.depth_key));
      if (held_cnt >= DBS_POOL_SIZE) begin
        ovf_seen = 1'b1;
      end else begin
        held_handle[held_cnt] = req_mon.prim_handle;
        held_bucket[held_cnt] = bkt;
        held_cnt++;
      end
    end else begin
      emitted = 0;
      if (held_cnt == 0) begin
        sorted_draws.push_back(make_draw('0, '0, 1'b1, 1'b1));
      end else begin
        // highest bucket first; arrival order within a bucket
        for (int b = DBS_BUCKETS - 1; b >= 0; b--) begin
          for (int i = 0; i < held_cnt; i++) begin
            if (held_bucket[i] == b) begin
              emitted++;
              sorted_draws.push_back(make_draw(held_handle[i], held_bucket[i], 1'b0,
                                               emitted == held_cnt));
            end
          end
        end
      end
      held_cnt = 0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic check_result();
    if (sorted_draws.size() == 0) begin
      report_mismatch($sformatf("unexpected result handle %h bucket %0d",
                                res_mon.out_handle, res_mon.out_bucket));
      return;
    end
    want = sorted_draws.pop_front();
    if (res_mon.out_handle !== want.handle)
      report_mismatch($sformatf("out_handle %h, want %h", res_mon.out_handle, want.handle));
    if (res_mon.out_bucket !== want.bucket)
      report_mismatch($sformatf("out_bucket %0d, want %0d (handle %h)",
                                res_mon.out_bucket, want.bucket, want.handle));
    if (res_mon.empty_res !== want.empty_res)
      report_mismatch($sformatf("empty_res %b, want %b", res_mon.empty_res, want.empty_res));
    if (res_mon.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, want %b", res_mon.overflow, want.overflow));
    if (res_mon.last !== want.last)
      report_mismatch($sformatf("last %b, want %b (handle %h)",
                                res_mon.last, want.last, want.handle));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) check_result();
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) predict_request();
    end
    pending_cnt <= sorted_draws.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: depth bucket sorter testbench
// Drives insert and flush requests through directed corner cases and random
// batches under changing sender/receiver idling; the order checker predicts
// and compares every result, this module decides the verdict.
// ----------------------------------------------------------------------------
module tb;
  import dbs_pkg::*;

  logic clk;
  logic rst_n;

  dbs_in_if  in_if ();
  dbs_out_if out_if ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // hold-off request from the stimulus; the receiver counts it down itself
  int unsigned hold_len       = 0;
  int unsigned hold_tag       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned req_total      = 0;

  depth_bucket_sorter_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  draw_order_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_mon      (in_if),
    .res_mon      (out_if),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result receiver: long hold-offs first, then random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_tag) begin
        hold_seen = hold_tag;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_req(input logic op, input logic signed [DBS_KEY_W-1:0] key,
                          input logic [DBS_HANDLE_W-1:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.depth_key   <= key;
    in_if.prim_handle <= handle;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    req_total++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // mostly a narrow window so buckets collect several primitives
  function automatic logic signed [DBS_KEY_W-1:0] pick_key(input int unsigned base);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return DBS_KEY_W'($urandom);
    if (sel == 1) return DBS_KEY_W'($urandom_range(DBS_BUCKETS - 1));
    return DBS_KEY_W'(base + $urandom_range(7));
  endfunction

  task automatic send_batch();
    int unsigned n;
    int unsigned base;
    base = $urandom_range(DBS_BUCKETS - 8);
    case ($urandom_range(5))
      0:       n = $urandom_range(DBS_POOL_SIZE + 8, DBS_POOL_SIZE);  // fills the pool
      1:       n = 0;
      default: n = $urandom_range(12, 1);
    endcase
    repeat (n) push_req(DBS_OP_INSERT, pick_key(base), DBS_HANDLE_W'($urandom));
    // noise: requests of either kind
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(3, 1))
        push_req(1'($urandom), DBS_KEY_W'($urandom), DBS_HANDLE_W'($urandom));
    push_req(DBS_OP_FLUSH, DBS_KEY_W'($urandom), DBS_HANDLE_W'($urandom));
  endtask

  initial begin
    int unsigned goal;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.operation   = DBS_OP_INSERT;
    in_if.depth_key   = '0;
    in_if.prim_handle = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty flush, clamping at both ends, shared buckets, back-to-back flush
    push_req(DBS_OP_FLUSH,  16'sh0000, 16'h0000);
    push_req(DBS_OP_INSERT, 16'sh8000, 16'hFFFF);
    push_req(DBS_OP_INSERT, 16'sh7FFF, 16'h0000);
    push_req(DBS_OP_INSERT, -16'sd1,   16'h1234);
    push_req(DBS_OP_INSERT, 16'sd0,    16'h8001);
    push_req(DBS_OP_INSERT, 16'sd1023, 16'h7FFE);
    push_req(DBS_OP_INSERT, 16'sd1024, 16'h00AA);
    push_req(DBS_OP_INSERT, 16'sd1022, 16'h5555);
    push_req(DBS_OP_INSERT, 16'sd1,    16'hAAAA);
    push_req(DBS_OP_INSERT, 16'sd1,    16'h0F0F);
    push_req(DBS_OP_INSERT, 16'sd512,  16'hF0F0);
    push_req(DBS_OP_INSERT, 16'sd512,  16'h1111);
    push_req(DBS_OP_FLUSH,  16'sh7FFF, 16'hFFFF);
    push_req(DBS_OP_FLUSH,  16'sh8000, 16'h0000);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (ph == 0) begin
        // receiver holds off a flush while more requests queue up behind it
        repeat (8) push_req(DBS_OP_INSERT, pick_key(100), DBS_HANDLE_W'($urandom));
        hold_len = 300;
        hold_tag++;
        push_req(DBS_OP_FLUSH, '0, '0);
        repeat (6) push_req(DBS_OP_INSERT, pick_key(40), DBS_HANDLE_W'($urandom));
        push_req(DBS_OP_FLUSH, '0, '0);
        wait_drained();
      end
      goal = req_total + 65;
      while (req_total < goal) send_batch();
      wait_drained();
    end

    repeat (64) @(posedge clk);
    if (mismatch_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: depth_bucket_sorter_unit.f
src/dbs_pkg.sv
src/dbs_if.sv
src/dbs_ctrl.sv
src/dbs_dp.sv
src/depth_bucket_sorter_unit.sv
test/draw_order_checker.sv
test/tb.sv
